FILE: rtl/core/tasr_pkg.sv
package tasr_pkg;

    localparam int unsigned CfgIdxW     = 3;
    localparam logic [15:0] CruiseBand  = 16'd50;

    typedef enum logic [CfgIdxW-1:0] {
        REG_PAD_ALT      = 3'd0,
        REG_CRUISE_ALT   = 3'd1,
        REG_RANGE_MIN    = 3'd2,
        REG_RANGE_HOLD   = 3'd3,
        REG_DIST_TRIGGER = 3'd4,
        REG_RAMP_STEP    = 3'd5
    } t_reg_idx;

    localparam logic [15:0] PadAltReset      = 16'd500;
    localparam logic [15:0] CruiseAltReset   = 16'd1500;
    localparam logic [15:0] RangeMinReset    = 16'd300;
    localparam logic [15:0] RangeHoldReset   = 16'd500;
    localparam logic [15:0] DistTriggerReset = 16'd1000;
    localparam logic [15:0] RampStepReset    = 16'd25;

    typedef enum logic [1:0] {
        PHASE_ON_PAD  = 2'd0,
        PHASE_RAMPING = 2'd1,
        PHASE_CRUISE  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [15:0] pad_altitude_mm;
        logic [15:0] cruise_altitude_mm;
        logic [15:0] range_min_mm;
        logic [15:0] range_hold_ms;
        logic [15:0] distance_trigger_mm;
        logic [15:0] ramp_step_mm;
    } t_cfg;

    typedef struct packed {
        logic        restart;
        logic        leave_req;
        logic        range_valid;
        logic [15:0] range_mm;
        logic [31:0] now_ms;
        logic [15:0] pad_distance_mm;
    } t_item;

    typedef struct packed {
        logic [15:0] setpoint;
        logic        confirmed;
        logic        hold_armed;
        logic [31:0] hold_start;
        t_phase      phase;
    } t_state;

    typedef struct packed {
        logic [15:0] setpoint_mm;
        logic        confirmed;
        t_phase      phase;
    } t_result;

endpackage

FILE: rtl/core/takeoff_altitude_setpoint_ramp.sv
// Takeoff altitude setpoint ramp. One item per 50 ms mission tick goes in and
// one result item comes out for each. An accepted item is registered; once the
// output register is free it is applied to the ramp state (off-pad latch, hold timer,
// setpoint, phase) and the result is registered on the output. A new item can
// be taken every cycle while the output is not blocked. The single state update
// stage is the only thing that paces the block; it holds only while a result
// waits on the output. The user must write registers through the cfg port only
// while no item is in flight; the block does not enforce this. A restart item
// reloads the setpoint from the pad altitude register and clears latch and timer.
module takeoff_altitude_setpoint_ramp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] leave_req, [1] range_valid, [17:2] range_mm, [49:18] now_ms,
    // [65:50] pad_distance_mm, [71:66] zero
    input  logic [71:0] i_s_axis_tdata,
    // [0] restart
    input  logic        i_s_axis_tuser,
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] setpoint_mm, [16] confirmed, [18:17] phase, [23:19] zero
    output logic [23:0] o_m_axis_tdata
);

    tasr_pkg::t_cfg    r_cfg;
    tasr_pkg::t_item   r_in;
    logic              r_in_valid;
    tasr_pkg::t_state  r_state;
    tasr_pkg::t_state  n_state;
    tasr_pkg::t_result r_out;
    tasr_pkg::t_result n_out;
    logic              r_out_valid;

    logic out_free;
    logic advance;
    logic in_accept;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pad_altitude_mm     <= tasr_pkg::PadAltReset;
            r_cfg.cruise_altitude_mm  <= tasr_pkg::CruiseAltReset;
            r_cfg.range_min_mm        <= tasr_pkg::RangeMinReset;
            r_cfg.range_hold_ms       <= tasr_pkg::RangeHoldReset;
            r_cfg.distance_trigger_mm <= tasr_pkg::DistTriggerReset;
            r_cfg.ramp_step_mm        <= tasr_pkg::RampStepReset;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tasr_pkg::REG_PAD_ALT:      r_cfg.pad_altitude_mm     <= i_cfg_wdata;
                tasr_pkg::REG_CRUISE_ALT:   r_cfg.cruise_altitude_mm  <= i_cfg_wdata;
                tasr_pkg::REG_RANGE_MIN:    r_cfg.range_min_mm        <= i_cfg_wdata;
                tasr_pkg::REG_RANGE_HOLD:   r_cfg.range_hold_ms       <= i_cfg_wdata;
                tasr_pkg::REG_DIST_TRIGGER: r_cfg.distance_trigger_mm <= i_cfg_wdata;
                tasr_pkg::REG_RAMP_STEP:    r_cfg.ramp_step_mm        <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.restart         <= i_s_axis_tuser;
            r_in.leave_req       <= i_s_axis_tdata[0];
            r_in.range_valid     <= i_s_axis_tdata[1];
            r_in.range_mm        <= i_s_axis_tdata[17:2];
            r_in.now_ms          <= i_s_axis_tdata[49:18];
            r_in.pad_distance_mm <= i_s_axis_tdata[65:50];
        end
    end

    tasr_next u_next (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.setpoint   <= tasr_pkg::PadAltReset;
            r_state.confirmed  <= 1'b0;
            r_state.hold_armed <= 1'b0;
            r_state.hold_start <= '0;
            r_state.phase      <= tasr_pkg::PHASE_ON_PAD;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.phase, r_out.confirmed, r_out.setpoint_mm};

    // restart item always yields an unlatched, on-pad result
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.restart |=> !r_out.confirmed && r_out.phase == tasr_pkg::PHASE_ON_PAD)
        else $error("restart did not clear latch and phase");

    // the off-pad latch only drops on a restart
    a_latch_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_state.confirmed) |-> $past(advance && r_in.restart))
        else $error("off-pad latch dropped without restart");

    // cruise phase only once confirmed
    a_cruise_confirmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.phase == tasr_pkg::PHASE_CRUISE |-> r_out.confirmed)
        else $error("cruise phase without confirmation");

    // a held item stays put while the output is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_state))
        else $error("item or state moved while stalled");

endmodule

FILE: rtl/core/tasr_next.sv
module tasr_next (
    input  tasr_pkg::t_cfg    i_cfg,
    input  tasr_pkg::t_state  i_state,
    input  tasr_pkg::t_item   i_item,
    output tasr_pkg::t_state  o_state,
    output tasr_pkg::t_result o_result
);

    logic        rng_good;
    logic [31:0] elapsed;
    logic        conf;
    logic [15:0] target;
    logic [15:0] diff;
    logic [15:0] setpoint;
    logic [15:0] band_diff;
    tasr_pkg::t_state  nxt;

    always_comb begin
        rng_good  = i_item.range_valid && (i_item.range_mm >= i_cfg.range_min_mm);
        elapsed   = i_item.now_ms - i_state.hold_start;
        nxt       = i_state;
        conf      = i_state.confirmed;

        if (!i_state.confirmed && i_item.leave_req) begin
            if (rng_good) begin
                if (!i_state.hold_armed) begin
                    nxt.hold_armed = 1'b1;
                    nxt.hold_start = i_item.now_ms;
                end else if (elapsed >= {16'd0, i_cfg.range_hold_ms}) begin
                    conf = 1'b1;
                end
            end else begin
                nxt.hold_armed = 1'b0;
                nxt.hold_start = '0;
            end
            if (i_item.pad_distance_mm >= i_cfg.distance_trigger_mm) begin
                conf = 1'b1;
            end
        end

        target = conf ? i_cfg.cruise_altitude_mm : i_cfg.pad_altitude_mm;
        diff   = (target >= i_state.setpoint) ? target - i_state.setpoint
                                              : i_state.setpoint - target;
        // a step past the target cannot wrap: diff > step keeps the sum in range
        if (i_cfg.ramp_step_mm == '0 || diff <= i_cfg.ramp_step_mm) begin
            setpoint = target;
        end else if (target > i_state.setpoint) begin
            setpoint = i_state.setpoint + i_cfg.ramp_step_mm;
        end else begin
            setpoint = i_state.setpoint - i_cfg.ramp_step_mm;
        end

        band_diff = (setpoint >= i_cfg.cruise_altitude_mm)
                  ? setpoint - i_cfg.cruise_altitude_mm
                  : i_cfg.cruise_altitude_mm - setpoint;

        nxt.setpoint  = setpoint;
        nxt.confirmed = conf;
        if (!conf) begin
            nxt.phase = tasr_pkg::PHASE_ON_PAD;
        end else if (band_diff <= tasr_pkg::CruiseBand) begin
            nxt.phase = tasr_pkg::PHASE_CRUISE;
        end else begin
            nxt.phase = tasr_pkg::PHASE_RAMPING;
        end

        if (i_item.restart) begin
            nxt.setpoint   = i_cfg.pad_altitude_mm;
            nxt.confirmed  = 1'b0;
            nxt.hold_armed = 1'b0;
            nxt.hold_start = '0;
            nxt.phase      = tasr_pkg::PHASE_ON_PAD;
        end

        o_state              = nxt;
        o_result.setpoint_mm = nxt.setpoint;
        o_result.confirmed   = nxt.confirmed;
        o_result.phase       = nxt.phase;
    end

endmodule
